### design/gbn_pkg.sv
// Shared constants, codes and control/status types for the go-back-n sender window.
package gbn_pkg;

	// Sizing
	localparam int WINDOW_MAX = 32;
	localparam int SEQ_BITS   = 16;
	localparam int WIN_BITS   = $clog2(WINDOW_MAX + 1);
	localparam int LIM_BITS   = SEQ_BITS + 1;
	localparam int FRAME_BITS = 16;
	localparam int WS_BITS    = 6;
	localparam int MODE_BITS  = 2;
	localparam int CFG_BITS   = 16;

	// Event codes on the input tuser
	localparam logic [MODE_BITS-1:0] MODE_START   = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_ACK     = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_TIMEOUT = 2'd2;

	// Result kinds on the output tuser
	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_EXIT  = 1'b1;

	// Configuration register indexes
	localparam logic REG_FRAME_COUNT = 1'b0;
	localparam logic REG_WINDOW_SIZE = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic take;   // input transaction accepted this cycle
		logic step;   // emit the next frame of a burst
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic slot_free;  // output register can take a result this cycle
		logic ev_burst;   // event on the input starts a non-empty burst
		logic step_last;  // current burst frame is the final one
	} dp_stat_t;

endpackage

### design/gbn_ctrl.sv
// Controller state machine: event acceptance and burst sequencing.
module gbn_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  gbn_pkg::dp_stat_t   stat,
	output gbn_pkg::ctrl_cmd_t  cmd
);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_BURST = 1'b1;

	logic state_q;
	logic state_d;

	// Accept only between bursts and when a result has somewhere to go
	assign s_tready = (state_q == ST_IDLE) && stat.slot_free;
	assign cmd.take = s_tvalid && s_tready;
	assign cmd.step = (state_q == ST_BURST) && stat.slot_free;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.take && stat.ev_burst) state_d = ST_BURST;
			end
			ST_BURST: begin
				if (cmd.step && stat.step_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule

### design/gbn_dp.sv
// Datapath: configuration, window state, burst counter and output register.
module gbn_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic                                  cfg_index,
	input  logic [gbn_pkg::CFG_BITS-1:0]          cfg_data,
	input  logic [gbn_pkg::MODE_BITS-1:0]         ev_mode,
	input  logic [gbn_pkg::FRAME_BITS-1:0]        ev_ack,
	input  gbn_pkg::ctrl_cmd_t                    cmd,
	output gbn_pkg::dp_stat_t                     stat,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic                                  out_kind,
	output logic [gbn_pkg::FRAME_BITS-1:0]        out_frame,
	output logic                                  out_last
);

	// Configuration registers
	logic [gbn_pkg::FRAME_BITS-1:0] frame_count_q;
	logic [gbn_pkg::WS_BITS-1:0]    window_size_q;

	// Window state
	logic [gbn_pkg::SEQ_BITS-1:0]   base_q;
	logic [gbn_pkg::SEQ_BITS-1:0]   next_q;
	logic [gbn_pkg::SEQ_BITS-1:0]   top_q;
	logic                           active_q;

	// Burst counter and its bound
	logic [gbn_pkg::SEQ_BITS-1:0]   cur_q;
	logic [gbn_pkg::LIM_BITS-1:0]   limit_q;

	// Output register
	logic                           out_valid_q;
	logic                           out_kind_q;
	logic [gbn_pkg::FRAME_BITS-1:0] out_frame_q;
	logic                           out_last_q;

	logic [gbn_pkg::WIN_BITS-1:0]   win;
	logic [gbn_pkg::LIM_BITS-1:0]   frames_x;
	logic [gbn_pkg::LIM_BITS-1:0]   win_x;
	logic [gbn_pkg::LIM_BITS-1:0]   start_lim;
	logic [gbn_pkg::LIM_BITS-1:0]   tmo_end;
	logic [gbn_pkg::LIM_BITS-1:0]   tmo_lim;
	logic                           is_start;
	logic                           is_ack;
	logic                           is_tmo;
	logic                           ack_exit;
	logic [gbn_pkg::SEQ_BITS-1:0]   base_adv;
	logic                           ack_room;
	logic                           ack_send;
	logic                           ack_emit;
	logic                           slot_free;

	// Window size clamped to 1..WINDOW_MAX
	always_comb begin
		if (window_size_q == '0) win = gbn_pkg::WIN_BITS'(1);
		else if (32'(window_size_q) > gbn_pkg::WINDOW_MAX)
			win = gbn_pkg::WIN_BITS'(gbn_pkg::WINDOW_MAX);
		else win = gbn_pkg::WIN_BITS'(window_size_q);
	end

	assign frames_x = gbn_pkg::LIM_BITS'(frame_count_q);
	assign win_x    = gbn_pkg::LIM_BITS'(win);

	// Burst bounds: start sends 0..min(frames, win)-1, timeout base..min(frames, base+win)-1
	assign start_lim = (frames_x < win_x) ? frames_x : win_x;
	assign tmo_end   = gbn_pkg::LIM_BITS'(base_q) + win_x;
	assign tmo_lim   = (frames_x < tmo_end) ? frames_x : tmo_end;

	assign is_start = (ev_mode == gbn_pkg::MODE_START);
	assign is_ack   = (ev_mode == gbn_pkg::MODE_ACK) && active_q;
	assign is_tmo   = (ev_mode == gbn_pkg::MODE_TIMEOUT) && active_q;

	// Acknowledgement: exit on the last frame, else exact-match base advance
	assign ack_exit = (gbn_pkg::LIM_BITS'(ev_ack) + gbn_pkg::LIM_BITS'(1)) == frames_x;
	assign base_adv = (gbn_pkg::LIM_BITS'(ev_ack) == gbn_pkg::LIM_BITS'(base_q))
		? base_q + gbn_pkg::SEQ_BITS'(1) : base_q;
	assign ack_room = ((top_q - base_adv) != (gbn_pkg::SEQ_BITS'(win) - gbn_pkg::SEQ_BITS'(1)))
		&& (gbn_pkg::LIM_BITS'(next_q) != frames_x);
	assign ack_send = is_ack && !ack_exit && ack_room;
	assign ack_emit = cmd.take && is_ack && (ack_exit || ack_room);

	assign slot_free = !out_valid_q || out_ready;

	// Status towards the controller
	assign stat.slot_free = slot_free;
	assign stat.ev_burst  = (is_start && (start_lim != '0))
		|| (is_tmo && (tmo_lim > gbn_pkg::LIM_BITS'(base_q)));
	assign stat.step_last = (gbn_pkg::LIM_BITS'(cur_q) + gbn_pkg::LIM_BITS'(1)) >= limit_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= gbn_pkg::FRAME_BITS'(1);
			window_size_q <= gbn_pkg::WS_BITS'(4);
		end else if (cfg_we) begin
			case (cfg_index)
				gbn_pkg::REG_FRAME_COUNT: frame_count_q <= cfg_data[gbn_pkg::FRAME_BITS-1:0];
				gbn_pkg::REG_WINDOW_SIZE: window_size_q <= cfg_data[gbn_pkg::WS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Window state and burst counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			next_q   <= '0;
			top_q    <= '0;
			active_q <= 1'b0;
			cur_q    <= '0;
			limit_q  <= '0;
		end else if (cmd.take) begin
			if (is_start) begin
				base_q   <= '0;
				top_q    <= gbn_pkg::SEQ_BITS'(win) - gbn_pkg::SEQ_BITS'(1);
				next_q   <= start_lim[gbn_pkg::SEQ_BITS-1:0];
				active_q <= 1'b1;
				cur_q    <= '0;
				limit_q  <= start_lim;
			end else if (is_ack) begin
				if (ack_exit) begin
					active_q <= 1'b0;
				end else begin
					base_q <= base_adv;
					if (ack_send) begin
						top_q  <= top_q + gbn_pkg::SEQ_BITS'(1);
						next_q <= next_q + gbn_pkg::SEQ_BITS'(1);
					end
				end
			end else if (is_tmo) begin
				cur_q   <= base_q;
				limit_q <= tmo_lim;
			end
		end else if (cmd.step) begin
			cur_q <= cur_q + gbn_pkg::SEQ_BITS'(1);
		end
	end

	// Output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (ack_emit || cmd.step) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	// Output register: payload
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			out_kind_q  <= gbn_pkg::KIND_FRAME;
			out_frame_q <= gbn_pkg::FRAME_BITS'(cur_q);
			out_last_q  <= stat.step_last;
		end else if (ack_emit) begin
			out_kind_q  <= ack_exit ? gbn_pkg::KIND_EXIT : gbn_pkg::KIND_FRAME;
			out_frame_q <= ack_exit ? '0 : gbn_pkg::FRAME_BITS'(next_q);
			out_last_q  <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_frame = out_frame_q;
	assign out_last  = out_last_q;

	// A new event and a burst step never share a cycle
	a_take_step_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> !cmd.step)
		else $error("event accepted during a burst step");

	// A burst step always stays below its bound
	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (gbn_pkg::LIM_BITS'(cur_q) < limit_q))
		else $error("burst step beyond its bound");

	// The exit marker ends the session
	a_exit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && is_ack && ack_exit) |=> !active_q)
		else $error("session still active after exit marker");

	// Every result loaded while the slot is free shows valid next cycle
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(ack_emit || cmd.step) |=> out_valid_q)
		else $error("loaded result not presented");

endmodule

### design/go_back_n_sender_window.sv
// Top level of the go-back-n sender window: controller plus datapath.
//
// Usage
//   Events enter on the s_ stream: tuser carries the event (start, acknowledgement,
//   timeout), tdata the acknowledged frame number. Results leave on the m_ stream:
//   tdata is the frame number to send, tuser marks a frame (0) or the exit marker
//   (1), and tlast flags the final result caused by one event.
//   frame_count and window_size are set through the cfg_ write port, by the user
//   only while idle; the block itself does not enforce this.
// Results and flow
//   An acknowledgement gives at most one result, presented the cycle after its
//   transaction; the next event may follow in the next cycle if m_tready is high.
//   Start and timeout give a burst of up to the clamped window size (1..32) frames,
//   one per cycle while m_tready is high, the first loaded once the controller
//   enters its burst state; s_tready is low while the burst counter runs.
// Reset: arst_n clears the session (idle), window state and output valid flag;
//   frame_count returns to 1 and window_size to 4.
// Receiver stall: with m_tready low the output register holds its result, the
//   burst counter waits and s_tready stays low; nothing is dropped.
module go_back_n_sender_window (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Configuration write port
	input  logic                                   cfg_we,
	input  logic                                   cfg_index,
	input  logic [gbn_pkg::CFG_BITS-1:0]           cfg_data,
	// Event stream
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [gbn_pkg::FRAME_BITS-1:0]         s_tdata,   // [15:0] ack_number
	input  logic [gbn_pkg::MODE_BITS-1:0]          s_tuser,   // [1:0] mode
	// Result stream
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [gbn_pkg::FRAME_BITS-1:0]         m_tdata,   // [15:0] frame_number
	output logic                                   m_tuser,   // [0] kind
	output logic                                   m_tlast    // last
);

	gbn_pkg::ctrl_cmd_t cmd;
	gbn_pkg::dp_stat_t  stat;

	gbn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gbn_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ev_mode   (s_tuser),
		.ev_ack    (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_kind  (m_tuser),
		.out_frame (m_tdata),
		.out_last  (m_tlast)
	);

endmodule
